// ----- rtl/core/qsd_pkg.sv -----
// Package for the quadrature step decoder: decoder tables, register map and shared types.
// Used by qsd_regs and quadrature_step_decoder_accel_top; no dependencies.
package qsd_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int NOW_BITS          = 32;
    localparam int STATE_BITS        = 3;
    localparam int ENTRY_BITS        = 6;
    localparam int MS_BITS           = 16;
    localparam int PADDR_BITS        = 4;
    localparam int PDATA_BITS        = 32;

    localparam logic [MS_BITS-1:0] FAST_MS_RESET = 16'd50;
    localparam logic [MS_BITS-1:0] SLOW_MS_RESET = 16'd100;

    localparam logic [1:0] MOVE_NONE = 2'b00;
    localparam logic [1:0] MOVE_CW   = 2'b01;
    localparam logic [1:0] MOVE_CCW  = 2'b10;

    localparam logic [STATE_BITS-1:0] START_STATE = 3'd0;
    localparam logic [STATE_BITS-1:0] HALF_LAST   = 3'd5;
    localparam logic [STATE_BITS-1:0] FULL_LAST   = 3'd6;

    typedef enum logic [1:0] {
        REG_HALF_STEP_MODE = 2'd0,
        REG_FAST_MS        = 2'd1,
        REG_SLOW_MS        = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic               half_step_mode;
        logic [MS_BITS-1:0] fast_ms;
        logic [MS_BITS-1:0] slow_ms;
        logic               mode_write;
    } cfg_t;

    // Entry layout: [5:4] move code, [2:0] next state
    localparam logic [ENTRY_BITS-1:0] HALF_ROWS [6][4] = '{
        '{6'h03, 6'h02, 6'h01, 6'h00},
        '{6'h23, 6'h00, 6'h01, 6'h00},
        '{6'h13, 6'h02, 6'h00, 6'h00},
        '{6'h03, 6'h05, 6'h04, 6'h00},
        '{6'h03, 6'h03, 6'h04, 6'h10},
        '{6'h03, 6'h05, 6'h03, 6'h20}
    };

    localparam logic [ENTRY_BITS-1:0] FULL_ROWS [7][4] = '{
        '{6'h00, 6'h02, 6'h04, 6'h00},
        '{6'h03, 6'h00, 6'h01, 6'h10},
        '{6'h03, 6'h02, 6'h00, 6'h00},
        '{6'h03, 6'h02, 6'h01, 6'h00},
        '{6'h06, 6'h00, 6'h04, 6'h00},
        '{6'h06, 6'h05, 6'h00, 6'h20},
        '{6'h06, 6'h05, 6'h04, 6'h00}
    };

    function automatic logic [ENTRY_BITS-1:0] table_lookup(
        input logic                  half_mode,
        input logic [STATE_BITS-1:0] row,
        input logic [1:0]            pins
    );
        logic [ENTRY_BITS-1:0] entry;
        if (half_mode) begin
            if (row > HALF_LAST) begin
                entry = HALF_ROWS[START_STATE][pins];
            end else begin
                entry = HALF_ROWS[row][pins];
            end
        end else begin
            if (row > FULL_LAST) begin
                entry = FULL_ROWS[START_STATE][pins];
            end else begin
                entry = FULL_ROWS[row][pins];
            end
        end
        return entry;
    endfunction

endpackage

// ----- rtl/core/qsd_regs.sv -----
// APB configuration registers of the quadrature step decoder.
// Depends on qsd_pkg for the register map and the cfg_t bundle.
module qsd_regs
    import qsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic               half_step_mode_reg;
    logic [MS_BITS-1:0] fast_ms_reg;
    logic [MS_BITS-1:0] slow_ms_reg;
    logic               wr_en;
    logic [1:0]         index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign index  = paddr[PADDR_BITS-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_step_mode_reg <= 1'b0;
            fast_ms_reg        <= FAST_MS_RESET;
            slow_ms_reg        <= SLOW_MS_RESET;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_HALF_STEP_MODE: half_step_mode_reg <= pwdata[0];
                REG_FAST_MS:        fast_ms_reg        <= pwdata[MS_BITS-1:0];
                REG_SLOW_MS:        slow_ms_reg        <= pwdata[MS_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_HALF_STEP_MODE: prdata = {{(PDATA_BITS-1){1'b0}}, half_step_mode_reg};
            REG_FAST_MS:        prdata = {{(PDATA_BITS-MS_BITS){1'b0}}, fast_ms_reg};
            REG_SLOW_MS:        prdata = {{(PDATA_BITS-MS_BITS){1'b0}}, slow_ms_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.half_step_mode = half_step_mode_reg;
    assign cfg.fast_ms        = fast_ms_reg;
    assign cfg.slow_ms        = slow_ms_reg;
    assign cfg.mode_write     = wr_en && (index == REG_HALF_STEP_MODE);

endmodule

// ----- rtl/core/quadrature_step_decoder_accel_top.sv -----
// Quadrature step decoder with speed-based acceleration: top level.
// Depends on qsd_pkg and qsd_regs.
// Registers: the input register captures an input transaction and the result register its
// result, held there while out_ready is low; the state updates with the result register.
// Throughput: one transaction per cycle unless out_ready stalls a full result register.
// Table lookup and elapsed-time compare lie between the input and the result register.
// Reset: decoder in start state, last detent time 0, full-step mode, thresholds 50 and 100.
module quadrature_step_decoder_accel_top
    import qsd_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  line_a,
    input  logic                  line_b,
    input  logic [NOW_BITS-1:0]   now_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [2:0]     step_value
);

    cfg_t                  cfg;
    logic                  in_valid_reg;
    logic [1:0]            pins_reg;
    logic [NOW_BITS-1:0]   now_reg;
    logic [STATE_BITS-1:0] state_reg;
    logic [STATE_BITS-1:0] state_next;
    logic [TIME_BITS-1:0]  last_reg;
    logic [TIME_BITS-1:0]  now_t;
    logic [TIME_BITS-1:0]  elapsed;
    logic [ENTRY_BITS-1:0] entry;
    logic [1:0]            mag;
    logic signed [2:0]     step_next;
    logic                  out_valid_reg;
    logic signed [2:0]     step_reg;
    logic                  advance;
    logic                  detent;

    qsd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pins_reg <= {line_a, line_b};
            now_reg  <= now_ms;
        end
    end

    always_comb
    begin
        entry   = table_lookup(cfg.half_step_mode, state_reg, pins_reg);
        now_t   = TIME_BITS'(now_reg);
        elapsed = now_t - last_reg;
        detent  = (entry[5:4] == MOVE_CW) || (entry[5:4] == MOVE_CCW);
        if (elapsed < TIME_BITS'(cfg.fast_ms))
        begin
            mag = 2'd3;
        end
        else if (elapsed < TIME_BITS'(cfg.slow_ms))
        begin
            mag = 2'd2;
        end
        else
        begin
            mag = 2'd1;
        end
        case (entry[5:4])
            MOVE_CW:  step_next = $signed({1'b0, mag});
            MOVE_CCW: step_next = -$signed({1'b0, mag});
            default:  step_next = 3'sd0;
        endcase
        state_next = entry[STATE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= START_STATE;
            last_reg  <= '0;
        end
        else if (cfg.mode_write)
        begin
            state_reg <= START_STATE;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            if (detent)
            begin
                last_reg <= now_t;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            step_reg <= step_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign step_value = step_reg;

    a_state_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.half_step_mode && state_reg <= HALF_LAST) ||
        (!cfg.half_step_mode && state_reg <= FULL_LAST))
        else $error("decoder state outside selected table");

    a_detent_time: assert property (@(posedge clk) disable iff (!rst_n)
        advance && detent && !cfg.mode_write |=> last_reg == $past(now_t))
        else $error("last detent time not updated on detent");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> step_reg != 3'b100)
        else $error("step value out of range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a full result register");

endmodule
